>>> rtl/fcv_pkg.sv
// ----------------------------------------------------------------------------
// fcv_pkg
// Shared types and constants of the frame chain validator.
// ----------------------------------------------------------------------------
package fcv_pkg;

	localparam int DATA_W      = 8;
	localparam int LEN_W       = 16;
	localparam int OFFSET_W    = 33;
	localparam int COUNT_W     = 17;
	localparam int STATUS_W    = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 17;
	localparam int OUT_TDATA_W = 56;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [DATA_W-1:0]  TYPE_STORED_RST = 8'd0;
	localparam logic [DATA_W-1:0]  TYPE_PACKED_RST = 8'd1;
	localparam logic [DATA_W-1:0]  TYPE_END_RST    = 8'd255;
	localparam logic [COUNT_W-1:0] MAX_FRAMES_RST  = 17'd100000;

	localparam logic [CFG_IDX_W-1:0] CFG_TYPE_STORED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TYPE_PACKED = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TYPE_END    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAMES  = 2'd3;

	typedef enum logic [STATUS_W-1:0] {
		ST_BUSY = 2'd0,
		ST_OK   = 2'd1,
		ST_ERR  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		PH_LEN_LO  = 2'd0,
		PH_LEN_HI  = 2'd1,
		PH_TYPE    = 2'd2,
		PH_PAYLOAD = 2'd3
	} phase_t;

	// one classified byte between front and back
	typedef struct packed {
		logic [DATA_W-1:0] data_byte;
		logic              buffer_end;
		logic              is_end;
		logic              is_data;
	} item_t;

endpackage

>>> rtl/frame_chain_validator.sv
// ----------------------------------------------------------------------------
// frame_chain_validator
// Checks a byte stream of length/type framed chunks up to a terminator frame.
// ----------------------------------------------------------------------------
// Each accepted byte passes through the FIFO before its result is registered.
// Throughput: one byte per cycle while m_tready does not stall the output;
// each byte yields one result transaction.
// The front tags bytes into a QUEUE_DEPTH-entry FIFO; the back walker and its
// output register drain it one entry per cycle unless the output is stalled.
// Reset: arst_n clears the walk, FIFO pointers and m_tvalid; config takes defaults.
module frame_chain_validator #(
	parameter int QUEUE_DEPTH = fcv_pkg::QUEUE_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [fcv_pkg::DATA_W-1:0]         s_tdata,   // [7:0] data_byte
	input  logic                               s_tlast,   // buffer_end
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [fcv_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [1:0] status,
	                                                      // [34:2] consumed_bytes,
	                                                      // [51:35] frame_count, [55:52] 0
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [fcv_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fcv_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic [fcv_pkg::DATA_W-1:0]  type_stored_q;
	logic [fcv_pkg::DATA_W-1:0]  type_packed_q;
	logic [fcv_pkg::DATA_W-1:0]  type_end_q;
	logic [fcv_pkg::COUNT_W-1:0] max_frames_q;

	logic           push, pop, q_full, q_empty;
	fcv_pkg::item_t push_item, pop_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_stored_q <= fcv_pkg::TYPE_STORED_RST;
			type_packed_q <= fcv_pkg::TYPE_PACKED_RST;
			type_end_q    <= fcv_pkg::TYPE_END_RST;
			max_frames_q  <= fcv_pkg::MAX_FRAMES_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				fcv_pkg::CFG_TYPE_STORED: type_stored_q <= cfg_data[fcv_pkg::DATA_W-1:0];
				fcv_pkg::CFG_TYPE_PACKED: type_packed_q <= cfg_data[fcv_pkg::DATA_W-1:0];
				fcv_pkg::CFG_TYPE_END:    type_end_q    <= cfg_data[fcv_pkg::DATA_W-1:0];
				fcv_pkg::CFG_MAX_FRAMES:  max_frames_q  <= cfg_data[fcv_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	fcv_front u_front (
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.type_stored (type_stored_q),
		.type_packed (type_packed_q),
		.type_end    (type_end_q),
		.q_full      (q_full),
		.push        (push),
		.push_item   (push_item)
	);

	fcv_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (q_empty)
	);

	fcv_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_item     (pop_item),
		.pop        (pop),
		.max_frames (max_frames_q),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule

>>> rtl/fcv_front.sv
// ----------------------------------------------------------------------------
// fcv_front
// Accepts stream bytes and tags each one against the configured type codes.
// ----------------------------------------------------------------------------
module fcv_front (
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [fcv_pkg::DATA_W-1:0]  s_tdata,   // [7:0] data_byte
	input  logic                        s_tlast,   // buffer_end
	input  logic [fcv_pkg::DATA_W-1:0]  type_stored,
	input  logic [fcv_pkg::DATA_W-1:0]  type_packed,
	input  logic [fcv_pkg::DATA_W-1:0]  type_end,
	input  logic                        q_full,
	output logic                        push,
	output fcv_pkg::item_t              push_item
);

	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	always_comb begin
		push_item.data_byte  = s_tdata;
		push_item.buffer_end = s_tlast;
		push_item.is_end     = (s_tdata == type_end);
		push_item.is_data    = (s_tdata == type_stored) || (s_tdata == type_packed);
	end

endmodule

>>> rtl/fcv_queue.sv
// ----------------------------------------------------------------------------
// fcv_queue
// Short FIFO of classified bytes between front and back.
// ----------------------------------------------------------------------------
module fcv_queue #(
	parameter int DEPTH = fcv_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  fcv_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output fcv_pkg::item_t pop_item,
	output logic           empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	fcv_pkg::item_t    mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full     = (count_q == FULL_CNT);
	assign empty    = (count_q == '0);
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/fcv_back.sv
// ----------------------------------------------------------------------------
// fcv_back
// Walks the frame chain one byte at a time and registers each result.
// ----------------------------------------------------------------------------
module fcv_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_empty,
	input  fcv_pkg::item_t                    q_item,
	output logic                              pop,
	input  logic [fcv_pkg::COUNT_W-1:0]       max_frames,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [fcv_pkg::OUT_TDATA_W-1:0]   m_tdata  // [1:0] status, [34:2] consumed_bytes,
	                                                   // [51:35] frame_count, [55:52] zero
);

	fcv_pkg::phase_t                 phase_q, phase_d;
	logic [fcv_pkg::DATA_W-1:0]      len_lo_q, len_lo_d;
	logic [fcv_pkg::LEN_W-1:0]       frame_len_q, frame_len_d;
	logic [fcv_pkg::LEN_W-1:0]       payload_left_q, payload_left_d;
	logic [fcv_pkg::OFFSET_W-1:0]    offset_q, offset_d, offset_inc;
	logic [fcv_pkg::COUNT_W-1:0]     frames_q, frames_d;

	fcv_pkg::status_t                status_d;
	logic [fcv_pkg::OFFSET_W-1:0]    consumed_d;
	logic [fcv_pkg::LEN_W-1:0]       pl_dec;

	logic                            m_valid_q;
	fcv_pkg::status_t                status_q;
	logic [fcv_pkg::OFFSET_W-1:0]    consumed_q;
	logic [fcv_pkg::COUNT_W-1:0]     count_q;

	assign pop      = !q_empty && (!m_valid_q || m_tready);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'd0, count_q, consumed_q, status_q};

	assign offset_inc = offset_q + 1'b1;

	always_comb begin
		phase_d        = phase_q;
		len_lo_d       = len_lo_q;
		frame_len_d    = frame_len_q;
		payload_left_d = payload_left_q;
		offset_d       = offset_inc;
		frames_d       = frames_q;
		status_d       = fcv_pkg::ST_BUSY;
		consumed_d     = '0;
		pl_dec         = payload_left_q;

		case (phase_q)
			fcv_pkg::PH_LEN_LO: begin
				len_lo_d = q_item.data_byte;
				phase_d  = fcv_pkg::PH_LEN_HI;
			end
			fcv_pkg::PH_LEN_HI: begin
				frame_len_d = {q_item.data_byte, len_lo_q};
				phase_d     = fcv_pkg::PH_TYPE;
			end
			fcv_pkg::PH_TYPE: begin
				if (q_item.is_end) begin
					if (frame_len_q != '0) begin
						status_d = fcv_pkg::ST_ERR;
					end else begin
						status_d   = fcv_pkg::ST_OK;
						consumed_d = offset_inc;
					end
				end else if (!q_item.is_data || frame_len_q == '0 ||
				             frames_q >= max_frames) begin
					status_d = fcv_pkg::ST_ERR;
				end else begin
					payload_left_d = frame_len_q;
					phase_d        = fcv_pkg::PH_PAYLOAD;
				end
			end
			fcv_pkg::PH_PAYLOAD: begin
				if (payload_left_q != '0) begin
					pl_dec = payload_left_q - 1'b1;
				end
				payload_left_d = pl_dec;
				if (pl_dec == '0) begin
					frames_d = frames_q + 1'b1;
					phase_d  = fcv_pkg::PH_LEN_LO;
				end
			end
			default: begin
				phase_d = fcv_pkg::PH_LEN_LO;
			end
		endcase

		if (status_d == fcv_pkg::ST_BUSY && q_item.buffer_end) begin
			status_d = fcv_pkg::ST_ERR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= fcv_pkg::PH_LEN_LO;
			len_lo_q       <= '0;
			frame_len_q    <= '0;
			payload_left_q <= '0;
			offset_q       <= '0;
			frames_q       <= '0;
			m_valid_q      <= 1'b0;
		end else begin
			if (pop) begin
				if (status_d != fcv_pkg::ST_BUSY) begin
					phase_q        <= fcv_pkg::PH_LEN_LO;
					len_lo_q       <= '0;
					frame_len_q    <= '0;
					payload_left_q <= '0;
					offset_q       <= '0;
					frames_q       <= '0;
				end else begin
					phase_q        <= phase_d;
					len_lo_q       <= len_lo_d;
					frame_len_q    <= frame_len_d;
					payload_left_q <= payload_left_d;
					offset_q       <= offset_d;
					frames_q       <= frames_d;
				end
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q   <= status_d;
			consumed_q <= consumed_d;
			count_q    <= frames_d;
		end
	end

endmodule
